@@ rtl/ptb_pkg.sv @@
// Package for the palindromic tree builder: sizes, widths and the sequencer state type.
package ptb_pkg;

    localparam int MAX_TEXT      = 256;
    localparam int ALPHABET_BITS = 8;

    localparam int NODE_DEPTH = MAX_TEXT + 2;
    localparam int NODE_W     = $clog2(NODE_DEPTH);
    localparam int TEXT_AW    = $clog2(MAX_TEXT);
    localparam int CNT_W      = $clog2(MAX_TEXT + 1);
    localparam int SYM_W      = ALPHABET_BITS;
    localparam int SYMBOLS    = 1 << ALPHABET_BITS;
    localparam int CHILD_AW   = NODE_W + SYM_W;
    localparam int CHILD_DEPTH = NODE_DEPTH * SYMBOLS;

    // Input byte and output field widths
    localparam int BYTE_W = 8;
    localparam int FLD_W  = 9;

    // Fixed node ids of the two roots
    localparam logic [NODE_W-1:0] ROOT_ODD  = NODE_W'(0);
    localparam logic [NODE_W-1:0] ROOT_EVEN = NODE_W'(1);

    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_LEN,
        S_TXT,
        S_CH2,
        S_CH3,
        S_OUT
    } ptb_state_t;

endpackage

@@ rtl/palindromic_tree_builder_core.sv @@
// Palindromic tree builder: eertree over a byte stream, one shared walk sequencer.
//
//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+-----------------------------------------
//  input   | in        | in_valid/in_stall  | text_byte
//  result  | out       | out_valid/out_stall| suffix_node, pal_length, is_new,
//          |           |                    | end_count, distinct_count, full_error
//
// For each byte, every node visited on either suffix-link walk is read from the node
// memories, then its byte is read from the text memory (skipped for the odd root or a
// node as long as the text); each walk ends with a child lookup and check in S_CH2 and
// S_CH3, and S_OUT loads the result before the return to idle. The single read port of
// each node/text memory sets the pace. A full text store goes straight to S_OUT.
// in_stall stays high while a byte is being worked; the result register lets a new
// byte enter while a result waits, and S_OUT holds while that result stays stalled.
// After reset a clearing pass zeroes the 66048 child table entries, one entry a cycle,
// with in_stall high.
module palindromic_tree_builder_core
    import ptb_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [BYTE_W-1:0]   text_byte,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [FLD_W-1:0]    suffix_node,
    output logic [FLD_W-1:0]    pal_length,
    output logic                is_new,
    output logic [FLD_W-1:0]    end_count,
    output logic [FLD_W-1:0]    distinct_count,
    output logic                full_error
);

    // Memories
    logic [SYM_W-1:0]  text_mem  [0:MAX_TEXT-1];
    logic [CNT_W-1:0]  len_mem   [0:NODE_DEPTH-1];
    logic [NODE_W-1:0] link_mem  [0:NODE_DEPTH-1];
    logic [CNT_W-1:0]  ends_mem  [0:NODE_DEPTH-1];
    logic [NODE_W-1:0] par_mem   [0:NODE_DEPTH-1];
    logic [SYM_W-1:0]  nsym_mem  [0:NODE_DEPTH-1];
    logic [NODE_W-1:0] child_mem [0:CHILD_DEPTH-1];

    logic [SYM_W-1:0]  text_q;
    logic [CNT_W-1:0]  len_q;
    logic [NODE_W-1:0] link_q;
    logic [CNT_W-1:0]  ends_q;
    logic [NODE_W-1:0] par_q;
    logic [SYM_W-1:0]  nsym_q;
    logic [NODE_W-1:0] child_q;

    ptb_state_t state_reg, state_next;

    logic [CHILD_AW-1:0] clr_reg, clr_next;
    logic [SYM_W-1:0]  sym_reg, sym_next;
    logic [CNT_W-1:0]  text_count_reg, text_count_next;
    logic [NODE_W-1:0] node_count_reg, node_count_next;
    logic [NODE_W-1:0] last_reg, last_next;
    logic [NODE_W-1:0] cur_reg, cur_next;
    logic [NODE_W-1:0] link_hold_reg, link_hold_next;
    logic [CNT_W-1:0]  len_hold_reg, len_hold_next;
    logic              walk2_reg, walk2_next;
    logic [NODE_W-1:0] par_reg, par_next;
    logic [CNT_W-1:0]  plen_reg, plen_next;
    logic [NODE_W-1:0] plink_reg, plink_next;
    logic [NODE_W-1:0] cand_reg, cand_next;

    logic [NODE_W-1:0] res_node_reg, res_node_next;
    logic [CNT_W-1:0]  res_len_reg, res_len_next;
    logic              res_new_reg, res_new_next;
    logic [CNT_W-1:0]  res_ends_reg, res_ends_next;
    logic              res_full_reg, res_full_next;

    logic              out_valid_reg, out_valid_next;
    logic [FLD_W-1:0]  o_node_reg, o_len_reg, o_ends_reg, o_dist_reg;
    logic              o_new_reg, o_full_reg;

    // Memory controls
    logic [NODE_W-1:0]  node_addr;
    logic [TEXT_AW-1:0] text_raddr;
    logic [CHILD_AW-1:0] child_raddr;
    logic [CHILD_AW-1:0] child_waddr;
    logic [NODE_W-1:0]  child_wdata;
    logic               ends_we, node_we, text_we, child_we;
    logic [CNT_W-1:0]   ends_wdata;
    logic [NODE_W-1:0]  new_link;
    logic [CNT_W-1:0]   new_len;

    // Walk helpers
    logic              accept;
    logic              cur_root;
    logic [CNT_W-1:0]  cur_len;
    logic [NODE_W-1:0] cur_link;
    logic [CNT_W-1:0]  txt_idx;
    logic              found;
    logic              cand_ok;
    logic              load_out;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign load_out = !out_valid_reg || !out_stall;
    assign cur_root = (cur_reg == ROOT_ODD) || (cur_reg == ROOT_EVEN);
    assign cur_len  = cur_root ? '0 : len_q;
    assign cur_link = cur_root ? ROOT_ODD : link_q;
    assign txt_idx  = text_count_reg - cur_len - CNT_W'(1);
    assign found    = (state_reg == S_LEN && cur_reg == ROOT_ODD) ||
                      (state_reg == S_TXT && text_q == sym_reg);
    assign cand_ok  = (cand_reg >= NODE_W'(2)) && (cand_reg < node_count_reg) &&
                      (par_q == cur_reg) && (nsym_q == sym_reg);
    assign new_len  = (par_reg == ROOT_ODD) ? CNT_W'(1) : plen_reg + CNT_W'(2);
    assign new_link = (walk2_reg && cand_ok) ? cand_reg : ROOT_EVEN;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLR:
            begin
                if (clr_reg == CHILD_AW'(CHILD_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = (text_count_reg == CNT_W'(MAX_TEXT)) ? S_OUT : S_LEN;
                end
            end
            S_LEN:
            begin
                if (found)
                begin
                    state_next = S_CH2;
                end
                else if (text_count_reg > cur_len)
                begin
                    state_next = S_TXT;
                end
            end
            S_TXT:
            begin
                state_next = found ? S_CH2 : S_LEN;
            end
            S_CH2:
            begin
                state_next = S_CH3;
            end
            S_CH3:
            begin
                if (!walk2_reg && !cand_ok && par_reg != ROOT_ODD)
                begin
                    state_next = S_LEN;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath and memory controls
    always_comb
    begin
        clr_next        = clr_reg;
        sym_next        = sym_reg;
        text_count_next = text_count_reg;
        node_count_next = node_count_reg;
        last_next       = last_reg;
        cur_next        = cur_reg;
        link_hold_next  = link_hold_reg;
        len_hold_next   = len_hold_reg;
        walk2_next      = walk2_reg;
        par_next        = par_reg;
        plen_next       = plen_reg;
        plink_next      = plink_reg;
        cand_next       = cand_reg;
        res_node_next   = res_node_reg;
        res_len_next    = res_len_reg;
        res_new_next    = res_new_reg;
        res_ends_next   = res_ends_reg;
        res_full_next   = res_full_reg;
        out_valid_next  = out_valid_reg && out_stall;
        node_addr       = cur_reg;
        text_raddr      = txt_idx[TEXT_AW-1:0];
        child_raddr     = {cur_reg, sym_reg};
        child_waddr     = {par_reg, sym_reg};
        child_wdata     = node_count_reg;
        ends_we         = 1'b0;
        ends_wdata      = ends_q + CNT_W'(1);
        node_we         = 1'b0;
        text_we         = 1'b0;
        child_we        = 1'b0;
        unique case (state_reg)
            S_CLR:
            begin
                // Zero one child table entry per cycle
                child_we    = 1'b1;
                child_waddr = clr_reg;
                child_wdata = '0;
                clr_next    = clr_reg + CHILD_AW'(1);
            end
            S_IDLE:
            begin
                sym_next      = text_byte[SYM_W-1:0];
                cur_next      = last_reg;
                node_addr     = last_reg;
                walk2_next    = 1'b0;
                res_full_next = 1'b1;
                res_node_next = '0;
                res_len_next  = '0;
                res_new_next  = 1'b0;
                res_ends_next = '0;
            end
            S_LEN:
            begin
                // Root -1 always extends; otherwise check the byte before
                link_hold_next = cur_link;
                len_hold_next  = cur_len;
                if (found)
                begin
                    child_raddr = {cur_reg, sym_reg};
                    if (!walk2_reg)
                    begin
                        par_next  = cur_reg;
                        plen_next = cur_len;
                    end
                end
                else if (!(text_count_reg > cur_len))
                begin
                    cur_next  = cur_link;
                    node_addr = cur_link;
                end
            end
            S_TXT:
            begin
                if (found)
                begin
                    child_raddr = {cur_reg, sym_reg};
                    if (!walk2_reg)
                    begin
                        par_next   = cur_reg;
                        plen_next  = len_hold_reg;
                        plink_next = link_hold_reg;
                    end
                end
                else
                begin
                    cur_next  = link_hold_reg;
                    node_addr = link_hold_reg;
                end
            end
            S_CH2:
            begin
                cand_next = child_q;
                node_addr = child_q;
            end
            S_CH3:
            begin
                if (!walk2_reg && cand_ok)
                begin
                    // Existing child
                    ends_we       = 1'b1;
                    res_node_next = cand_reg;
                    res_len_next  = len_q;
                    res_new_next  = 1'b0;
                    res_ends_next = ends_q + CNT_W'(1);
                    res_full_next = 1'b0;
                    last_next     = cand_reg;
                    text_we       = 1'b1;
                    text_count_next = text_count_reg + CNT_W'(1);
                end
                else if (!walk2_reg && par_reg != ROOT_ODD)
                begin
                    // Second walk for the new node's suffix link
                    walk2_next = 1'b1;
                    cur_next   = plink_reg;
                    node_addr  = plink_reg;
                end
                else
                begin
                    // Create node
                    node_we       = 1'b1;
                    ends_we       = 1'b1;
                    ends_wdata    = CNT_W'(1);
                    child_we      = 1'b1;
                    res_node_next = node_count_reg;
                    res_len_next  = new_len;
                    res_new_next  = 1'b1;
                    res_ends_next = CNT_W'(1);
                    res_full_next = 1'b0;
                    last_next     = node_count_reg;
                    node_count_next = node_count_reg + NODE_W'(1);
                    text_we       = 1'b1;
                    text_count_next = text_count_reg + CNT_W'(1);
                end
            end
            S_OUT:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                out_valid_next = out_valid_reg && out_stall;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLR;
            clr_reg        <= '0;
            text_count_reg <= '0;
            node_count_reg <= NODE_W'(2);
            last_reg       <= ROOT_EVEN;
            walk2_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_reg        <= clr_next;
            text_count_reg <= text_count_next;
            node_count_reg <= node_count_next;
            last_reg       <= last_next;
            walk2_reg      <= walk2_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        sym_reg       <= sym_next;
        cur_reg       <= cur_next;
        link_hold_reg <= link_hold_next;
        len_hold_reg  <= len_hold_next;
        par_reg       <= par_next;
        plen_reg      <= plen_next;
        plink_reg     <= plink_next;
        cand_reg      <= cand_next;
        res_node_reg  <= res_node_next;
        res_len_reg   <= res_len_next;
        res_new_reg   <= res_new_next;
        res_ends_reg  <= res_ends_next;
        res_full_reg  <= res_full_next;
        if (state_reg == S_OUT && load_out)
        begin
            o_node_reg <= FLD_W'(res_node_reg);
            o_len_reg  <= FLD_W'(res_len_reg);
            o_new_reg  <= res_new_reg;
            o_ends_reg <= FLD_W'(res_ends_reg);
            o_dist_reg <= FLD_W'(node_count_reg - NODE_W'(2));
            o_full_reg <= res_full_reg;
        end
    end

    // Memory ports: registered reads, one write each
    always_ff @(posedge clk)
    begin
        text_q  <= text_mem[text_raddr];
        len_q   <= len_mem[node_addr];
        link_q  <= link_mem[node_addr];
        ends_q  <= ends_mem[node_addr];
        par_q   <= par_mem[node_addr];
        nsym_q  <= nsym_mem[node_addr];
        child_q <= child_mem[child_raddr];
        if (text_we)
        begin
            text_mem[text_count_reg[TEXT_AW-1:0]] <= sym_reg;
        end
        if (ends_we)
        begin
            ends_mem[node_we ? node_count_reg : cand_reg] <= ends_wdata;
        end
        if (node_we)
        begin
            len_mem[node_count_reg]  <= new_len;
            link_mem[node_count_reg] <= new_link;
            par_mem[node_count_reg]  <= par_reg;
            nsym_mem[node_count_reg] <= sym_reg;
        end
        if (child_we)
        begin
            child_mem[child_waddr] <= child_wdata;
        end
    end

    assign out_valid      = out_valid_reg;
    assign suffix_node    = o_node_reg;
    assign pal_length     = o_len_reg;
    assign is_new         = o_new_reg;
    assign end_count      = o_ends_reg;
    assign distinct_count = o_dist_reg;
    assign full_error     = o_full_reg;

endmodule

@@ rtl/ptb_checker.sv @@
// Port-level checker for the palindromic tree builder, bound to the top level.
module ptb_checker
    import ptb_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input logic              out_valid,
    input logic              out_stall,
    input logic [FLD_W-1:0]  suffix_node,
    input logic [FLD_W-1:0]  pal_length,
    input logic              is_new,
    input logic [FLD_W-1:0]  end_count,
    input logic [FLD_W-1:0]  distinct_count,
    input logic              full_error
);

    // A stalled result transaction holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(suffix_node) && $stable(end_count))
        else $error("stalled result changed");

    // Busy after every accepted byte
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("accepted byte while busy");

    // Refused byte reports an empty result
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && full_error |-> suffix_node == '0 && pal_length == '0 &&
                                    end_count == '0 && !is_new)
        else $error("refused byte with nonzero result");

    // A new node is the newest one and has ended once
    a_new: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_new |-> end_count == FLD_W'(1) &&
                                suffix_node == distinct_count + FLD_W'(1))
        else $error("new node fields inconsistent");

    // Accepted bytes never land on a root
    a_nonroot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !full_error |-> suffix_node >= FLD_W'(2) && pal_length != '0)
        else $error("suffix node is a root");

endmodule

bind palindromic_tree_builder_core ptb_checker u_ptb_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .suffix_node    (suffix_node),
    .pal_length     (pal_length),
    .is_new         (is_new),
    .end_count      (end_count),
    .distinct_count (distinct_count),
    .full_error     (full_error)
);
